// ----- sv/vad_seg_pkg.sv -----
// Shared types and constants for the speech segmenter.
package vad_seg_pkg;

   // Field widths of the stream items and registers.
   localparam int PROB_BITS  = 16;
   localparam int FRAME_BITS = 20;
   localparam int END_BITS   = 21;
   localparam int NUM_BITS   = 16;
   localparam int CFG_BITS   = 16;
   localparam int IDX_BITS   = 2;

   // Width used for run length comparisons, wide enough for any run counter.
   localparam int CMP_BITS = 33;

   // Packed result data width, rounded up to whole bytes.
   localparam int RSP_BITS      = FRAME_BITS + END_BITS + NUM_BITS;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // Configuration register indexes.
   localparam logic [IDX_BITS-1:0] REG_SPEECH_THRESHOLD   = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_MIN_SPEECH_FRAMES  = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_MIN_SILENCE_FRAMES = 2'd2;

   // Register values after reset.
   localparam logic [CFG_BITS-1:0] RST_SPEECH_THRESHOLD   = 16'd32768;
   localparam logic [CFG_BITS-1:0] RST_MIN_SPEECH_FRAMES  = 16'd25;
   localparam logic [CFG_BITS-1:0] RST_MIN_SILENCE_FRAMES = 16'd10;

   // One segment result.
   typedef struct packed {
      logic [NUM_BITS-1:0]   segment_number;
      logic [END_BITS-1:0]   seg_end_frame;
      logic [FRAME_BITS-1:0] seg_start_frame;
   } seg_result_type;

endpackage

// ----- sv/vad_speech_segmenter_top.sv -----
// Speech segmenter: per-frame probability in, speech segment boundaries out.
// A result appears on the rsp_ side in the cycle after the transfer of the frame that causes it.
// Throughput: one frame per cycle unless a waiting result is not taken; all updates are compares and counter steps
// between the input transfer and the result register.
// A new frame is taken while a result waits, as long as the result register is taken.
// Reset is synchronous: registers return to their defaults and all segment state clears.
module vad_speech_segmenter_top
   import vad_seg_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Frame input
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [PROB_BITS-1:0]     req_tdata,   // [15:0] probability
   input  logic                     req_tlast,   // last_frame
   // Segment output
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [19:0] seg_start_frame,
                                                 // [40:20] seg_end_frame,
                                                 // [56:41] segment_number, rest zero
   output logic                     rsp_tuser,   // closed_by_end
   // Configuration writes
   input  logic                     csr_wen,
   input  logic [IDX_BITS-1:0]      csr_index,
   input  logic [CFG_BITS-1:0]      csr_wdata
);

   logic [COUNT_BITS-1:0] run_max;

   // Configuration registers
   logic [CFG_BITS-1:0] threshold_ff;
   logic [CFG_BITS-1:0] min_speech_ff;
   logic [CFG_BITS-1:0] min_silence_ff;

   // Segmenter state
   logic                  in_speech_ff,    in_speech_in;
   logic [COUNT_BITS-1:0] speech_run_ff,   speech_run_in;
   logic [COUNT_BITS-1:0] silence_run_ff,  silence_run_in;
   logic [FRAME_BITS-1:0] frame_index_ff,  frame_index_in;
   logic [FRAME_BITS-1:0] open_start_ff,   open_start_in;
   logic [NUM_BITS-1:0]   emitted_ff,      emitted_in;

   // Result register
   logic                  rsp_valid_ff;
   seg_result_type        rsp_data_ff,     rsp_data_in;
   logic                  rsp_by_end_ff,   rsp_by_end_in;

   logic                  accept;
   logic                  is_speech;
   logic                  open_seg;
   logic                  close_seg;
   logic                  emit_close;
   logic                  emit_end;
   logic                  emit;
   logic [CMP_BITS-1:0]   speech_run_wide;
   logic [CMP_BITS-1:0]   silence_run_wide;
   logic [FRAME_BITS-1:0] frame_next;
   logic [FRAME_BITS-1:0] open_at;
   logic [FRAME_BITS-1:0] close_at;
   logic [FRAME_BITS-1:0] seg_len;

   assign run_max = '1;

   // A frame may enter whenever the result register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= RST_SPEECH_THRESHOLD;
         min_speech_ff  <= RST_MIN_SPEECH_FRAMES;
         min_silence_ff <= RST_MIN_SILENCE_FRAMES;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_SPEECH_THRESHOLD:   threshold_ff   <= csr_wdata;
            REG_MIN_SPEECH_FRAMES:  min_speech_ff  <= csr_wdata;
            REG_MIN_SILENCE_FRAMES: min_silence_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Run counters saturate; a speech frame clears the silence run and vice versa.
   always_comb begin
      is_speech      = req_tdata >= threshold_ff;
      speech_run_in  = '0;
      silence_run_in = '0;
      if (is_speech) begin
         speech_run_in = (speech_run_ff == run_max) ? run_max
                                                    : speech_run_ff + 1'b1;
      end else begin
         silence_run_in = (silence_run_ff == run_max) ? run_max
                                                      : silence_run_ff + 1'b1;
      end
      speech_run_wide  = CMP_BITS'(speech_run_in);
      silence_run_wide = CMP_BITS'(silence_run_in);
   end

   // Segment boundaries, all modulo the frame index range.
   always_comb begin
      frame_next = frame_index_ff + 1'b1;
      open_at    = frame_next - speech_run_wide[FRAME_BITS-1:0];
      close_at   = frame_next - silence_run_wide[FRAME_BITS-1:0];
      seg_len    = close_at - open_start_ff;

      open_seg   = is_speech && !in_speech_ff
                   && (speech_run_wide >= CMP_BITS'(min_speech_ff));
      close_seg  = !is_speech && in_speech_ff
                   && (silence_run_wide >= CMP_BITS'(min_silence_ff));
      emit_close = close_seg && (seg_len >= FRAME_BITS'(min_speech_ff));

      in_speech_in  = open_seg ? 1'b1 : (close_seg ? 1'b0 : in_speech_ff);
      open_start_in = open_seg ? open_at : open_start_ff;

      // A segment still open at the clip's last frame is flushed unchecked.
      emit_end = req_tlast && in_speech_in && !emit_close;
      emit     = emit_close || emit_end;

      emitted_in = (emit && (emitted_ff != '1)) ? emitted_ff + 1'b1 : emitted_ff;

      rsp_data_in.segment_number = emitted_ff;
      if (emit_close) begin
         rsp_data_in.seg_start_frame = open_start_ff;
         rsp_data_in.seg_end_frame   = END_BITS'(close_at);
         rsp_by_end_in               = 1'b0;
      end else begin
         rsp_data_in.seg_start_frame = open_start_in;
         rsp_data_in.seg_end_frame   = END_BITS'(frame_index_ff) + 1'b1;
         rsp_by_end_in               = 1'b1;
      end

      frame_index_in = frame_next;
   end

   // State update on each input transfer; the last frame clears everything.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_speech_ff   <= 1'b0;
         speech_run_ff  <= '0;
         silence_run_ff <= '0;
         frame_index_ff <= '0;
         open_start_ff  <= '0;
         emitted_ff     <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            in_speech_ff   <= 1'b0;
            speech_run_ff  <= '0;
            silence_run_ff <= '0;
            frame_index_ff <= '0;
            open_start_ff  <= '0;
            emitted_ff     <= '0;
         end else begin
            in_speech_ff   <= in_speech_in;
            speech_run_ff  <= speech_run_in;
            silence_run_ff <= silence_run_in;
            frame_index_ff <= frame_index_in;
            open_start_ff  <= open_start_in;
            emitted_ff     <= emitted_in;
         end
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, loaded only when a segment is emitted.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_by_end_ff <= rsp_by_end_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);
   assign rsp_tuser  = rsp_by_end_ff;

endmodule

// ----- tb/vad_seg_checker.sv -----
// Checker for the speech segmenter: predicts segments from observed transfers and compares.
module vad_seg_checker
   import vad_seg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [PROB_BITS-1:0]     req_tdata,   // [15:0] probability
   input  logic                     req_tlast,   // last_frame
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [19:0] seg_start_frame,
                                                 // [40:20] seg_end_frame,
                                                 // [56:41] segment_number
   input  logic                     rsp_tuser,   // closed_by_end
   input  logic                     csr_wen,
   input  logic [IDX_BITS-1:0]      csr_index,
   input  logic [CFG_BITS-1:0]      csr_wdata,
   output int                       fail_count,
   output int                       waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] RUN_FULL   = 16'hFFFF;
   localparam logic [15:0] COUNT_FULL = 16'hFFFF;
   localparam int          MAX_SHOWN  = 40;

   // One predicted segment.
   typedef struct {
      logic [FRAME_BITS-1:0] first_frame;
      logic [END_BITS-1:0]   past_frame;
      logic [NUM_BITS-1:0]   seg_count;
      logic                  by_end;
   } seg_expect_type;

   seg_expect_type segments_due[$];

   // Register copies, tracked from the write port.
   logic [CFG_BITS-1:0] thr_level;
   logic [CFG_BITS-1:0] min_speech;
   logic [CFG_BITS-1:0] min_silence;

   // Segmenter state.
   logic                  talking;
   logic [15:0]           speech_len;
   logic [15:0]           silence_len;
   logic [FRAME_BITS-1:0] frame_pos;
   logic [FRAME_BITS-1:0] open_at;
   logic [NUM_BITS-1:0]   seg_total;

   initial begin
      fail_count = 0;
      waiting    = 0;
   end

   function automatic void clear_clip();
      talking     = 1'b0;
      speech_len  = '0;
      silence_len = '0;
      frame_pos   = '0;
      open_at     = '0;
      seg_total   = '0;
   endfunction

   // Builds a segment and advances the saturating emitted count.
   function automatic seg_expect_type take_segment(input logic [FRAME_BITS-1:0] first,
                                                   input logic [END_BITS-1:0] past,
                                                   input logic closed_at_end);
      seg_expect_type seg;
      seg.first_frame = first;
      seg.past_frame  = past;
      seg.seg_count   = seg_total;
      seg.by_end      = closed_at_end;
      if (seg_total != COUNT_FULL) seg_total = seg_total + 16'd1;
      return seg;
   endfunction

   // Advances the segmenter by one frame; returns 1 when a segment comes out.
   function automatic bit step_segmenter(input logic [PROB_BITS-1:0] prob,
                                         input logic last,
                                         output seg_expect_type seg);
      logic [FRAME_BITS-1:0] t;
      logic [FRAME_BITS-1:0] stop;
      logic [FRAME_BITS-1:0] span;
      bit                    got;
      got = 1'b0;
      seg = '{default: '0};
      t   = frame_pos;
      if (prob >= thr_level) begin
         speech_len  = (speech_len == RUN_FULL) ? RUN_FULL : speech_len + 16'd1;
         silence_len = '0;
         if (!talking && speech_len >= min_speech) begin
            talking = 1'b1;
            open_at = t + 20'd1 - 20'(speech_len);
         end
      end else begin
         silence_len = (silence_len == RUN_FULL) ? RUN_FULL : silence_len + 16'd1;
         speech_len  = '0;
         if (talking && silence_len >= min_silence) begin
            // The segment ends at the first frame of the silence run.
            stop    = t + 20'd1 - 20'(silence_len);
            span    = stop - open_at;
            talking = 1'b0;
            if (span >= 20'(min_speech)) begin
               seg = take_segment(open_at, {1'b0, stop}, 1'b0);
               got = 1'b1;
            end
         end
      end
      // The last frame closes what is still open, unless a silence close came out.
      if (last) begin
         if (talking && !got) begin
            seg = take_segment(open_at, 21'(t) + 21'd1, 1'b1);
            got = 1'b1;
         end
         clear_clip();
      end else begin
         frame_pos = t + 20'd1;
      end
      return got;
   endfunction

   task automatic report_field(input string label, input logic [END_BITS-1:0] want,
                               input logic [END_BITS-1:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_SHOWN)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // Watch all three ports on each rising edge.
   always @(posedge clock) begin
      seg_expect_type want;
      seg_expect_type pred;
      seg_result_type seen;
      if (reset) begin
         thr_level   = RST_SPEECH_THRESHOLD;
         min_speech  = RST_MIN_SPEECH_FRAMES;
         min_silence = RST_MIN_SILENCE_FRAMES;
         clear_clip();
         segments_due.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_SPEECH_THRESHOLD:   thr_level   = csr_wdata;
               REG_MIN_SPEECH_FRAMES:  min_speech  = csr_wdata;
               REG_MIN_SILENCE_FRAMES: min_silence = csr_wdata;
               default: ;
            endcase
         end
         // Results come from earlier frames, so compare before predicting.
         if (rsp_tvalid && rsp_tready) begin
            seen = seg_result_type'(rsp_tdata[RSP_BITS-1:0]);
            if (segments_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("%0t ns: unexpected segment, expected none, actual %0d..%0d",
                           $time, seen.seg_start_frame, seen.seg_end_frame);
            end else begin
               want = segments_due.pop_front();
               report_field("seg_start_frame", 21'(want.first_frame), 21'(seen.seg_start_frame));
               report_field("seg_end_frame", want.past_frame, seen.seg_end_frame);
               report_field("segment_number", 21'(want.seg_count), 21'(seen.segment_number));
               report_field("closed_by_end", 21'(want.by_end), 21'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready) begin
            if (step_segmenter(req_tdata, req_tlast, pred))
               segments_due.insert(segments_due.size(), pred);
         end
      end
      waiting = segments_due.size();
   end

endmodule

// ----- tb/tb_vad_speech_segmenter_top.sv -----
// Testbench top for the speech segmenter: clock, reset, frame stimulus and verdict.
module tb_vad_speech_segmenter_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vad_seg_pkg::*;

   localparam int LIMIT      = 2_000_000;
   localparam int LONG_HOLD  = 400;
   localparam int SETTLE     = 4;
   localparam int TAIL       = 8;
   localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [PROB_BITS-1:0]     req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_wen    = 1'b0;
   logic [IDX_BITS-1:0]      csr_index  = '0;
   logic [CFG_BITS-1:0]      csr_wdata  = '0;

   int fail_count;
   int waiting;
   int cycles    = 0;
   int send_pct  = 29;
   int recv_pct  = 76;
   bit hold_armed = 1'b0;
   bit hold_done  = 1'b0;

   // Settings currently loaded, used to shape the frames.
   logic [CFG_BITS-1:0] cur_thr     = RST_SPEECH_THRESHOLD;
   logic [CFG_BITS-1:0] cur_min_sp  = RST_MIN_SPEECH_FRAMES;
   logic [CFG_BITS-1:0] cur_min_sil = RST_MIN_SILENCE_FRAMES;

   vad_speech_segmenter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   vad_seg_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .waiting    (waiting)
   );

   always #2 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Segment receiver: random back-pressure, plus one long hold when armed.
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_pct);
      end
   end

   // Offers one frame, with random gaps before it, and waits for its transfer.
   task automatic drive_frame(input logic [PROB_BITS-1:0] prob, input logic last);
      while ($urandom_range(0, 99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= prob;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Waits until every predicted segment has arrived and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (waiting != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Loads all registers; the unused index gets random data and must be ignored.
   task automatic set_config(input logic [CFG_BITS-1:0] thr, input logic [CFG_BITS-1:0] sp,
                             input logic [CFG_BITS-1:0] sil);
      write_reg(REG_UNUSED, 16'($urandom));
      write_reg(REG_SPEECH_THRESHOLD, thr);
      write_reg(REG_MIN_SPEECH_FRAMES, sp);
      write_reg(REG_MIN_SILENCE_FRAMES, sil);
      csr_wen     <= 1'b0;
      cur_thr     = thr;
      cur_min_sp  = sp;
      cur_min_sil = sil;
   endtask

   // A probability that counts as speech, now and then exactly at the threshold.
   function automatic logic [PROB_BITS-1:0] speech_prob();
      if ($urandom_range(0, 9) == 0) return cur_thr;
      return 16'(int'(cur_thr) + $urandom_range(0, 65535 - int'(cur_thr)));
   endfunction

   // A probability below the threshold, now and then just below it; any value when the threshold is zero.
   function automatic logic [PROB_BITS-1:0] silence_prob();
      if (cur_thr == 0) return 16'($urandom);
      if ($urandom_range(0, 9) == 0) return cur_thr - 16'd1;
      return 16'($urandom_range(0, int'(cur_thr) - 1));
   endfunction

   // One clip of alternating speech and silence bursts, with some noise frames.
   task automatic send_clip(inout int sent);
      int clip_len, burst, i, cap_sp, cap_sil;
      bit talking, noisy;
      logic [PROB_BITS-1:0] p;
      clip_len = $urandom_range(6, 60);
      noisy    = ($urandom_range(0, 9) == 0);
      cap_sp   = (cur_min_sp > 12) ? 12 : int'(cur_min_sp);
      cap_sil  = (cur_min_sil > 10) ? 10 : int'(cur_min_sil);
      talking  = $urandom_range(0, 1);
      i = 0;
      while (i < clip_len) begin
         burst = talking ? $urandom_range(0, cap_sp + 3) : $urandom_range(0, cap_sil + 3);
         repeat (burst) begin
            if (i < clip_len) begin
               if (noisy || $urandom_range(0, 99) < 8) p = 16'($urandom);
               else p = talking ? speech_prob() : silence_prob();
               drive_frame(p, i == clip_len - 1);
               i++;
               sent++;
            end
         end
         talking = !talking;
      end
   endtask

   // Picks a value, sometimes one of the extremes.
   function automatic logic [CFG_BITS-1:0] pick_value(input int hi);
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, hi));
      endcase
   endfunction

   initial begin : stimulus
      int sent, k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: threshold boundary, silence close, and close by the last frame.
      set_config(16'h8000, 16'd2, 16'd2);
      drive_frame(16'hFFFF, 1'b0);
      drive_frame(16'hFFFF, 1'b0);
      drive_frame(16'h8000, 1'b0);
      drive_frame(16'h7FFF, 1'b0);
      drive_frame(16'h0000, 1'b0);
      drive_frame(16'h8000, 1'b0);
      drive_frame(16'h8000, 1'b0);
      drive_frame(16'h0000, 1'b1);
      settle();

      // Directed: zero minimum speech, and a silence close on the last frame.
      set_config(16'h8000, 16'd0, 16'd1);
      drive_frame(16'hFFFF, 1'b0);
      drive_frame(16'h0000, 1'b1);
      drive_frame(16'h0000, 1'b0);
      drive_frame(16'hFFFF, 1'b0);
      drive_frame(16'h0000, 1'b0);
      drive_frame(16'hFFFF, 1'b1);
      settle();

      // Directed: register extremes.
      set_config(16'h0000, 16'hFFFF, 16'hFFFF);
      drive_frame(16'h0000, 1'b1);
      settle();
      set_config(16'hFFFF, 16'd1, 16'd0);
      drive_frame(16'hFFFF, 1'b0);
      drive_frame(16'hFFFE, 1'b0);
      drive_frame(16'hFFFF, 1'b1);
      settle();

      // Long receiver hold while frames keep coming, so the input stalls.
      send_pct = 0;
      recv_pct = 0;
      set_config(16'h8000, 16'd0, 16'd1);
      hold_armed = 1'b1;
      for (k = 0; k < 80; k++) drive_frame(k[0] ? 16'h0100 : 16'hF000, k == 79);
      settle();

      // Random clips over three idling patterns and several settings each.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_pct = 29; recv_pct = 76; end
            1: begin send_pct = 76; recv_pct = 29; end
            default: begin send_pct = 0; recv_pct = 0; end
         endcase
         for (int s = 0; s < 4; s++) begin
            settle();
            set_config(pick_value(65535), pick_value(8), pick_value(5));
            sent = 0;
            while (sent < 125) send_clip(sent);
         end
      end
      settle();

      repeat (TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
